>>> rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared widths, opcodes, constants and the slot update command for the
// key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // returned on a get miss
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // broadcast to every slot, the slot's own target bit picks the one written
    typedef struct packed {
        logic             update;
        logic             age_all;
        logic             write_key;
        logic             write_value;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot_cmd;

endpackage

>>> rtl/core/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// Request and response channels of the key/value cache.
// ----------------------------------------------------------------------------
interface lkv_req_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;

    modport source (output valid, output opcode, output lookup_key,
                    output store_value, input ready);
    modport sink   (input valid, input opcode, input lookup_key,
                    input store_value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

>>> rtl/core/lkv_slot.sv
// ----------------------------------------------------------------------------
// lkv_slot
// One cache entry: valid bit, key, value and age rank, with its own key
// compare and least-recent detect.
// ----------------------------------------------------------------------------
module lkv_slot #(
    parameter int RW = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lkv_pkg::t_slot_cmd       i_cmd,
    input  logic                     i_target,
    input  logic [RW-1:0]            i_age,
    input  logic [RW-1:0]            i_oldest_rank,
    output logic                     o_valid,
    output logic                     o_match,
    output logic                     o_oldest,
    output logic [lkv_pkg::VAL_W-1:0] o_value,
    output logic [RW-1:0]            o_recency
);
    import lkv_pkg::*;

    logic             r_valid;
    logic [RW-1:0]    r_rec;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rec   <= '0;
        end else if (i_cmd.update) begin
            if (i_target) begin
                r_valid <= 1'b1;
                r_rec   <= '0;
            end else if (r_valid && (i_cmd.age_all || (r_rec < i_age))) begin
                r_rec <= r_rec + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && i_target) begin
            if (i_cmd.write_key) begin
                r_key <= i_cmd.key;
            end
            if (i_cmd.write_value) begin
                r_value <= i_cmd.value;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_match   = r_valid && (r_key == i_cmd.key);
    assign o_oldest  = r_valid && (r_rec == i_oldest_rank);
    assign o_value   = r_value;
    assign o_recency = r_rec;

endmodule

>>> rtl/core/lkv_select.sv
// ----------------------------------------------------------------------------
// lkv_select
// Reduces the per-slot flags: hit value and age by one-hot and-or, and the
// lowest free slot.
// ----------------------------------------------------------------------------
module lkv_select #(
    parameter int ENTRIES = 16,
    parameter int RW      = 4
) (
    input  logic [ENTRIES-1:0]                     i_valid,
    input  logic [ENTRIES-1:0]                     i_match,
    input  logic [ENTRIES-1:0][lkv_pkg::VAL_W-1:0] i_value,
    input  logic [ENTRIES-1:0][RW-1:0]             i_recency,
    output logic                                   o_hit,
    output logic [lkv_pkg::VAL_W-1:0]              o_hit_value,
    output logic [RW-1:0]                          o_hit_age,
    output logic [ENTRIES-1:0]                     o_free_onehot
);
    import lkv_pkg::*;

    logic [ENTRIES-1:0] free_vec;

    // keys are unique among valid slots, so at most one match
    always_comb begin
        o_hit_value = '0;
        o_hit_age   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            o_hit_value = o_hit_value | (i_value[i] & {VAL_W{i_match[i]}});
            o_hit_age   = o_hit_age | (i_recency[i] & {RW{i_match[i]}});
        end
    end

    assign o_hit         = |i_match;
    assign free_vec      = ~i_valid;
    assign o_free_onehot = free_vec & (~free_vec + 1'b1);

endmodule

>>> rtl/core/lru_key_value_cache.sv
// Flow: a get word goes from the input register through the slot lookup
//   to the result register; a put gives no result and never waits on it.
// Throughput: one word per cycle while no get waits on an unread result,
//   set by the single lookup-and-update pass over all slots.
// Reset: synchronous; clears every slot's valid bit and age, the fill count
//   and both channel valid flags, and sets the capacity register to 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_wdata,
    lkv_req_if.sink                   i_req,
    lkv_rsp_if.source                 o_rsp
);
    import lkv_pkg::*;

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // input register
    logic             r_in_valid;
    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // state and result register
    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_fill;
    logic             r_out_valid;
    logic             r_found;
    logic [VAL_W-1:0] r_read_value;

    logic                             adv;
    logic                             in_take;
    logic [ENTRIES-1:0]               valid_vec;
    logic [ENTRIES-1:0]               match_vec;
    logic [ENTRIES-1:0]               oldest_vec;
    logic [ENTRIES-1:0]               free_onehot;
    logic [ENTRIES-1:0]               target_vec;
    logic [ENTRIES-1:0][VAL_W-1:0]    value_arr;
    logic [ENTRIES-1:0][RW-1:0]       rec_arr;
    logic                             hit;
    logic [VAL_W-1:0]                 hit_value;
    logic [RW-1:0]                    hit_age;
    logic [RW-1:0]                    oldest_rank;
    logic [RW-1:0]                    age;
    logic [LW-1:0]                    eff_lim;
    logic                             at_limit;
    t_slot_cmd                        cmd;

    // a put never needs the result register
    assign adv     = r_in_valid && ((r_op == OP_PUT) || !r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;
    assign in_take = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_req.opcode;
            r_key <= KEY_W'(i_req.lookup_key);
            r_val <= VAL_W'(i_req.store_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // capacity zero acts as one, above the slot count it saturates
    always_comb begin
        eff_lim = LW'(r_cap);
        if (r_cap == '0) begin
            eff_lim = LW'(1);
        end
        if (eff_lim > LW'(ENTRIES)) begin
            eff_lim = LW'(ENTRIES);
        end
    end

    assign at_limit    = LW'(r_fill) >= eff_lim;
    assign oldest_rank = RW'(r_fill - CW'(1));

    always_comb begin
        if (hit) begin
            target_vec = match_vec;
        end else if (at_limit) begin
            target_vec = oldest_vec;
        end else begin
            target_vec = free_onehot;
        end
    end

    assign age             = hit ? hit_age : oldest_rank;
    assign cmd.update      = adv && (hit || (r_op == OP_PUT));
    assign cmd.age_all     = !hit && !at_limit;
    assign cmd.write_key   = !hit;
    assign cmd.write_value = (r_op == OP_PUT);
    assign cmd.key         = r_key;
    assign cmd.value       = r_val;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
        lkv_slot #(
            .RW(RW)
        ) u_slot (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_target     (target_vec[g]),
            .i_age        (age),
            .i_oldest_rank(oldest_rank),
            .o_valid      (valid_vec[g]),
            .o_match      (match_vec[g]),
            .o_oldest     (oldest_vec[g]),
            .o_value      (value_arr[g]),
            .o_recency    (rec_arr[g])
        );
    end

    lkv_select #(
        .ENTRIES(ENTRIES),
        .RW     (RW)
    ) u_select (
        .i_valid      (valid_vec),
        .i_match      (match_vec),
        .i_value      (value_arr),
        .i_recency    (rec_arr),
        .o_hit        (hit),
        .o_hit_value  (hit_value),
        .o_hit_age    (hit_age),
        .o_free_onehot(free_onehot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (adv && (r_op == OP_PUT) && !hit && !at_limit) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && (r_op == OP_GET)) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && (r_op == OP_GET)) begin
            r_found      <= hit;
            r_read_value <= hit ? hit_value : MISS_VALUE;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.read_value = r_read_value;

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(match_vec) <= 1)
        else $error("key present in more than one slot");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_fill))
        else $error("fill count disagrees with valid slots");

    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_fill >= $past(r_fill))
        else $error("fill count shrank");

    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> $onehot(oldest_vec))
        else $error("least recent slot not unique");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache: drives get and put words,
// mirrors the slot store and recency ranks, and checks every get result.
// ----------------------------------------------------------------------------
module tb;
    import lkv_pkg::*;

    localparam int ENTRIES  = 16;
    localparam int IDLE_PCT = 22;
    localparam int POOL_MAX = 24;
    localparam int HOLD_LEN = 150;

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] value;
    } t_read_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lkv_req_if req_bus ();
    lkv_rsp_if rsp_bus ();

    lru_key_value_cache #(.ENTRIES(ENTRIES)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    // mirror of the slot store
    logic             mirror_valid [ENTRIES];
    logic [KEY_W-1:0] mirror_key   [ENTRIES];
    logic [VAL_W-1:0] mirror_value [ENTRIES];
    int unsigned      mirror_age   [ENTRIES];
    int unsigned      mirror_fill;
    logic [CAP_W-1:0] mirror_capacity;

    t_read_result     pending_reads[$];
    int               fail_count     = 0;
    bit               send_idle_en   = 1'b1;
    bit               recv_idle_en   = 1'b1;
    int               stall_requests = 0;
    logic [KEY_W-1:0] key_pool [POOL_MAX];

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("lru_key_value_cache: mismatch");
        $finish;
    end

    function automatic void mirror_reset();
        for (int i = 0; i < ENTRIES; i++) begin
            mirror_valid[i] = 1'b0;
            mirror_key[i]   = '0;
            mirror_value[i] = '0;
            mirror_age[i]   = 0;
        end
        mirror_fill     = 0;
        mirror_capacity = CAP_RESET;
    endfunction

    // slot becomes most recent, only slots younger than it age by one
    function automatic void mirror_promote(int s);
        int unsigned rank;
        rank = mirror_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (mirror_valid[i] && i != s && mirror_age[i] < rank)
                mirror_age[i]++;
        mirror_age[s] = 0;
    endfunction

    function automatic void predict_request(logic op, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
        int           hit;
        int           victim;
        int unsigned  limit;
        bit           placed;
        t_read_result res;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && mirror_valid[i] && mirror_key[i] == key)
                hit = i;

        if (op == OP_GET) begin
            if (hit >= 0) begin
                mirror_promote(hit);
                res.found = 1'b1;
                res.value = mirror_value[hit];
            end else begin
                res.found = 1'b0;
                res.value = MISS_VALUE;
            end
            pending_reads.push_back(res);
            return;
        end

        if (hit >= 0) begin
            mirror_value[hit] = val;
            mirror_promote(hit);
            return;
        end

        limit = (mirror_capacity == 0) ? 1 : mirror_capacity;
        if (limit > ENTRIES)
            limit = ENTRIES;

        if (mirror_fill >= limit) begin
            // full at the current limit: reuse the least recent slot
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (mirror_valid[i] && (victim < 0 || mirror_age[i] > mirror_age[victim]))
                    victim = i;
            mirror_key[victim]   = key;
            mirror_value[victim] = val;
            mirror_promote(victim);
            return;
        end

        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!placed && !mirror_valid[i]) begin
                for (int j = 0; j < ENTRIES; j++)
                    if (mirror_valid[j])
                        mirror_age[j]++;
                mirror_valid[i] = 1'b1;
                mirror_key[i]   = key;
                mirror_value[i] = val;
                mirror_age[i]   = 0;
                mirror_fill++;
                placed = 1'b1;
            end
        end
    endfunction

    task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        while (send_idle_en && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.opcode      <= op;
        req_bus.lookup_key  <= key;
        req_bus.store_value <= val;
        @(posedge i_clk);
        while (!req_bus.ready)
            @(posedge i_clk);
        predict_request(op, key, val);
    endtask

    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        // a trailing put may still be in flight
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror_capacity = cap;
    endtask

    task automatic test_empty_lookups();
        send_word(OP_GET, 32'h8000_0000, 32'h0);
        send_word(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_store_extremes();
        send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        // value -1 on a hit must still report found
        send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_GET, 32'h8000_0000, 32'h0);
        send_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_word(OP_GET, 32'h0000_0000, 32'h0);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_word(OP_GET, 32'h0000_0000, 32'h0);
    endtask

    task automatic test_capacity_shrink();
        // four slots filled, limit dropped to one: each new key replaces the oldest
        set_capacity(5'd1);
        send_word(OP_PUT, 32'h0000_0005, 32'hA5A5_5A5A);
        send_word(OP_GET, 32'h0000_0005, 32'h0);
        send_word(OP_GET, 32'h8000_0000, 32'h0);
        send_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_word(OP_PUT, 32'h0000_0006, 32'h5A5A_A5A5);
        send_word(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_word(OP_GET, 32'h0000_0005, 32'h0);
    endtask

    task automatic test_random_traffic(input int count, input int pool_size);
        logic             op;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = $urandom();
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(99) < 50) ? OP_PUT : OP_GET;
            if ($urandom_range(99) < 88)
                key = key_pool[$urandom_range(pool_size - 1)];
            else
                key = $urandom();
            send_word(op, key, $urandom());
        end
    endtask

    task automatic test_capacity_sweep();
        logic [CAP_W-1:0] caps [8];
        caps = '{5'd16, 5'd1, 5'd2, 5'd7, 5'd16, 5'd12, 5'd4, 5'd16};
        foreach (caps[p]) begin
            set_capacity(caps[p]);
            // one phase runs with both sides streaming
            send_idle_en = (p != 3);
            recv_idle_en = (p != 3);
            test_random_traffic(175, (caps[p] + 3 > POOL_MAX) ? POOL_MAX : caps[p] + 3);
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure();
        send_idle_en = 1'b0;
        stall_requests++;
        test_random_traffic(48, 10);
        send_idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.opcode      <= OP_GET;
        req_bus.lookup_key  <= '0;
        req_bus.store_value <= '0;
        mirror_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookups();
        test_store_extremes();
        test_capacity_shrink();
        test_capacity_sweep();
        test_output_backpressure();

        drain_results();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("lru_key_value_cache: match");
        else
            $display("lru_key_value_cache: mismatch");
        $finish;
    end

    // result ready, with random idling and one long hold-off on request
    initial begin : rsp_ready_drive
        int hold_left;
        int stalls_seen;
        hold_left   = 0;
        stalls_seen = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_requests != stalls_seen) begin
                stalls_seen = stall_requests;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (recv_idle_en) begin
                rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : read_check
        t_read_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected word found=%0b read_value=%h",
                         $time, rsp_bus.found, rsp_bus.read_value);
                fail_count++;
            end else begin
                want = pending_reads.pop_front();
                if (rsp_bus.found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, rsp_bus.found);
                    fail_count++;
                end
                if (rsp_bus.read_value !== want.value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.value, rsp_bus.read_value);
                    fail_count++;
                end
            end
        end
    end

endmodule
